// ===== rtl/u8tw_pkg.sv =====
// shared types and constants of the utf-8 text width measure block
// no dependencies; compiled first
`timescale 1ns / 1ps

package u8tw_pkg;

    localparam int unsigned U8TW_RESULT_DEPTH = 4;

    localparam logic [7:0]  CFG_FONT_SIZE  = 8'd0;
    localparam logic [7:0]  CFG_FONT_STYLE = 8'd1;

    localparam logic [7:0]  FONT_SIZE_RESET  = 8'd1;
    localparam logic [7:0]  FONT_STYLE_RESET = 8'd0;

    localparam logic [7:0]  STYLE_BOLD  = 8'd1;
    localparam logic [7:0]  STYLE_WIDE  = 8'd2;
    localparam logic [7:0]  STYLE_BLOCK = 8'd3;

    localparam logic [15:0] BAD_CODE   = 16'd63;
    localparam logic [15:0] SHARP_S    = 16'h00DF;
    localparam logic [14:0] WIDTH_MAX  = 15'h7FFF;

    typedef struct packed {
        logic [15:0] codepoint;
        logic        glyph_present;
        logic [4:0]  advance;
        logic [14:0] total_width;
        logic        width_saturated;
        logic        last_result;
    } t_result;

    // results produced by one byte, slot a first
    typedef struct packed {
        logic [1:0] count;
        t_result    a;
        t_result    b;
    } t_push;

    typedef struct packed {
        logic room;
    } t_queue_stat;

endpackage

// ===== rtl/u8tw_ifs.sv =====
// valid/ready channel interfaces: text bytes in, results out, config writes
// no dependencies
`timescale 1ns / 1ps

interface u8tw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;
    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8tw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] codepoint;
    logic        glyph_present;
    logic [4:0]  advance;
    logic [14:0] total_width;
    logic        width_saturated;
    logic        last_result;
    modport source (output valid, output codepoint, output glyph_present, output advance,
                    output total_width, output width_saturated, output last_result,
                    input ready);
    modport sink   (input valid, input codepoint, input glyph_present, input advance,
                    input total_width, input width_saturated, input last_result,
                    output ready);
endinterface

interface u8tw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/u8tw_cfg_regs.sv =====
// font size and font style registers behind the config write channel
// depends on u8tw_pkg and u8tw_cfg_if
`timescale 1ns / 1ps

module u8tw_cfg_regs (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8tw_cfg_if.sink   i_cfg,
    output logic [7:0] o_font_size,
    output logic [7:0] o_font_style
);
    import u8tw_pkg::*;

    logic [7:0] r_font_size;
    logic [7:0] r_font_style;

    assign i_cfg.ready  = 1'b1;
    assign o_font_size  = r_font_size;
    assign o_font_style = r_font_style;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_size  <= FONT_SIZE_RESET;
            r_font_style <= FONT_STYLE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FONT_SIZE:  r_font_size  <= i_cfg.data;
                CFG_FONT_STYLE: r_font_style <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/u8tw_decode.sv =====
// input register, utf-8 decode state, glyph advance and running width
// depends on u8tw_pkg and u8tw_in_if
`timescale 1ns / 1ps

module u8tw_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8tw_in_if.sink           i_text,
    input  logic [7:0]        i_font_size,
    input  logic [7:0]        i_font_style,
    input  u8tw_pkg::t_queue_stat i_stat,
    output u8tw_pkg::t_push   o_push
);
    import u8tw_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_second, n_second;
    logic [1:0]  r_pending, n_pending;
    logic        r_skip, n_skip;
    logic [14:0] r_sum, n_sum;
    logic        r_clip, n_clip;

    logic        consume;
    logic        a_v, b_v, a_last;
    logic [15:0] a_cp, b_cp;
    logic [4:0]  a_adv, b_adv;
    t_result     res_a, res_b;

    function automatic logic [4:0] glyph_adv(input logic [15:0] cp,
                                             input logic [7:0] size_raw,
                                             input logic [7:0] style);
        logic [1:0] size;
        logic [4:0] base;
        logic [4:0] extra;
        size  = (size_raw >= 8'd2) ? 2'd2 : 2'd1;
        base  = (cp == SHARP_S) ? 5'd12 : 5'd6;
        extra = 5'd0;
        if (style == STYLE_BOLD || style == STYLE_BLOCK) begin
            extra = 5'd1;
        end else if (style == STYLE_WIDE) begin
            extra = {3'd0, size};
        end
        glyph_adv = ((size == 2'd2) ? {base[3:0], 1'b0} : base) + extra;
    endfunction

    function automatic t_result make_result(input logic [15:0] cp, input logic last,
                                            input logic [4:0] adv,
                                            input logic [14:0] sum_in,
                                            input logic clip_in);
        t_result    r;
        logic [15:0] s;
        s = {1'b0, sum_in} + {11'd0, adv};
        r.codepoint = cp;
        if (cp == 16'd0) begin
            // end marker
            r.glyph_present   = 1'b0;
            r.advance         = 5'd0;
            r.total_width     = sum_in;
            r.width_saturated = clip_in;
            r.last_result     = 1'b1;
        end else begin
            r.glyph_present   = 1'b1;
            r.advance         = adv;
            r.total_width     = s[15] ? WIDTH_MAX : s[14:0];
            r.width_saturated = clip_in | s[15];
            r.last_result     = last;
        end
        make_result = r;
    endfunction

    assign consume      = r_in_valid && i_stat.room;
    assign i_text.ready = !r_in_valid || consume;

    always_comb begin
        a_v       = 1'b0;
        a_cp      = 16'd0;
        a_last    = 1'b0;
        b_v       = 1'b0;
        b_cp      = 16'd0;
        n_lead    = r_lead;
        n_second  = r_second;
        n_pending = r_pending;
        if (!r_skip) begin
            case (r_pending)
                2'd1: begin
                    n_pending = 2'd0;
                    a_v       = 1'b1;
                    a_last    = r_last;
                    a_cp      = (r_lead[7:5] == 3'b110)
                              ? {5'd0, r_lead[4:0], r_byte[5:0]}
                              : {r_lead[3:0], r_second[5:0], r_byte[5:0]};
                end
                2'd2: begin
                    if (r_last) begin
                        // three-byte sequence cut short: '?' then this byte as a lead
                        n_pending = 2'd0;
                        a_v       = 1'b1;
                        a_cp      = BAD_CODE;
                        b_v       = 1'b1;
                        b_cp      = r_byte[7] ? BAD_CODE : {8'd0, r_byte};
                    end else begin
                        n_second  = r_byte;
                        n_pending = 2'd1;
                    end
                end
                default: begin
                    n_pending = 2'd0;
                    a_last    = r_last;
                    if (!r_byte[7]) begin
                        a_v  = 1'b1;
                        a_cp = {8'd0, r_byte};
                    end else if (r_byte[7:5] == 3'b110 && !r_last) begin
                        n_lead    = r_byte;
                        n_pending = 2'd1;
                    end else if (r_byte[7:4] == 4'b1110 && !r_last) begin
                        n_lead    = r_byte;
                        n_pending = 2'd2;
                    end else begin
                        a_v  = 1'b1;
                        a_cp = BAD_CODE;
                    end
                end
            endcase
        end

        a_adv = glyph_adv(a_cp, i_font_size, i_font_style);
        b_adv = glyph_adv(b_cp, i_font_size, i_font_style);
        res_a = make_result(a_cp, a_last, a_adv, r_sum, r_clip);
        res_b = make_result(b_cp, 1'b1, b_adv, res_a.total_width, res_a.width_saturated);

        n_skip = r_skip | (a_v && a_cp == 16'd0) | (b_v && b_cp == 16'd0);
        if (b_v) begin
            n_sum  = res_b.total_width;
            n_clip = res_b.width_saturated;
        end else if (a_v) begin
            n_sum  = res_a.total_width;
            n_clip = res_a.width_saturated;
        end else begin
            n_sum  = r_sum;
            n_clip = r_clip;
        end

        // end of text returns all decode state to its reset value
        if (r_last) begin
            n_lead    = 8'd0;
            n_second  = 8'd0;
            n_pending = 2'd0;
            n_skip    = 1'b0;
            n_sum     = 15'd0;
            n_clip    = 1'b0;
        end

        o_push.a     = res_a;
        o_push.b     = res_b;
        o_push.count = consume ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_lead     <= 8'd0;
            r_second   <= 8'd0;
            r_pending  <= 2'd0;
            r_skip     <= 1'b0;
            r_sum      <= 15'd0;
            r_clip     <= 1'b0;
        end else begin
            if (i_text.ready) begin
                r_in_valid <= i_text.valid;
            end
            if (consume) begin
                r_lead    <= n_lead;
                r_second  <= n_second;
                r_pending <= n_pending;
                r_skip    <= n_skip;
                r_sum     <= n_sum;
                r_clip    <= n_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_byte <= i_text.text_byte;
            r_last <= i_text.end_of_text;
        end
    end

endmodule

// ===== rtl/u8tw_result_queue.sv =====
// result queue: takes up to two results a cycle, hands one a cycle to the sink while it is ready
// depends on u8tw_pkg and u8tw_out_if
`timescale 1ns / 1ps

module u8tw_result_queue #(
    parameter int unsigned DEPTH = u8tw_pkg::U8TW_RESULT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  u8tw_pkg::t_push       i_push,
    output u8tw_pkg::t_queue_stat o_stat,
    u8tw_out_if.source            o_result
);
    import u8tw_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          pop;
    logic [AW-1:0] wr_b;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign pop    = o_result.valid && o_result.ready;
    assign wr_b   = ptr_inc(r_wr);
    assign n_wr   = (i_push.count == 2'd2) ? ptr_inc(wr_b)
                  : (i_push.count == 2'd1) ? wr_b : r_wr;
    assign o_stat.room = (r_count <= ROOM_MAX);

    assign o_result.valid           = (r_count != '0);
    assign o_result.codepoint       = r_mem[r_rd].codepoint;
    assign o_result.glyph_present   = r_mem[r_rd].glyph_present;
    assign o_result.advance         = r_mem[r_rd].advance;
    assign o_result.total_width     = r_mem[r_rd].total_width;
    assign o_result.width_saturated = r_mem[r_rd].width_saturated;
    assign o_result.last_result     = r_mem[r_rd].last_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= r_count + CW'(i_push.count) - CW'(pop);
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_b] <= i_push.b;
        end
    end

endmodule

// ===== rtl/utf8_text_width_measure_core.sv =====
// UTF-8 text width measure: decodes text bytes and keeps the running glyph width
// top level; depends on u8tw_pkg, u8tw_ifs, u8tw_cfg_regs, u8tw_decode, u8tw_result_queue
//
// usage
//   i_text carries one text byte per transfer, end_of_text set on the final byte.
//   o_result gives one result per transfer: codepoint, advance, running width,
//   saturation flag and last_result on the final result of a text. a byte may
//   give no result (lead or middle byte of a sequence), one, or two (a three-byte
//   sequence cut short by the end of the text gives '?' and then the last byte).
//   i_cfg writes font_size (index 0) and font_style (index 1); write only while
//   no text byte is in flight. it is always ready.
//   a result passes the input register and then the result queue before it
//   can be taken. throughput: one byte per cycle while the queue has room,
//   set by the single decode/width-add stage; the two results of one byte
//   reach the sink in separate transfers.
//   stall: results wait in a queue of RESULT_DEPTH entries; i_text keeps taking
//   bytes as long as the queue has room for two more results.
//   reset: decode state and running width are cleared, font_size returns to 1,
//   font_style to 0, the queue is emptied.
`timescale 1ns / 1ps

module utf8_text_width_measure_core #(
    parameter int unsigned RESULT_DEPTH = u8tw_pkg::U8TW_RESULT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8tw_in_if.sink    i_text,
    u8tw_cfg_if.sink   i_cfg,
    u8tw_out_if.source o_result
);
    import u8tw_pkg::*;

    logic [7:0]  font_size;
    logic [7:0]  font_style;
    t_push       push;
    t_queue_stat stat;

    u8tw_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_font_size  (font_size),
        .o_font_style (font_style)
    );

    u8tw_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (i_text),
        .i_font_size  (font_size),
        .i_font_style (font_style),
        .i_stat       (stat),
        .o_push       (push)
    );

    u8tw_result_queue #(
        .DEPTH (RESULT_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_stat   (stat),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // results are only pushed when the queue reported room for two
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 |-> stat.room)
        else $error("result pushed without queue room");

    // two results from one byte only for a truncated sequence
    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count == 2'd2 |-> push.a.codepoint == BAD_CODE && !push.a.last_result
                               && push.b.last_result)
        else $error("bad two-result push");

    // an end marker has no advance and closes the text
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 && !push.a.glyph_present |->
            push.a.last_result && push.a.advance == 5'd0 && push.count == 2'd1)
        else $error("malformed end marker");
`endif

endmodule

// ===== tb/tb_utf8_text_width_measure_core.sv =====
// testbench for utf8_text_width_measure_core: streams utf-8 texts, predicts each result
// depends on u8tw_pkg, u8tw_ifs and the rtl of the core
`timescale 1ns / 1ps

module tb_utf8_text_width_measure_core;
    import u8tw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8tw_in_if  text_if ();
    u8tw_out_if res_if ();
    u8tw_cfg_if cfg_if ();

    utf8_text_width_measure_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    always #4 i_clk = ~i_clk;

    // pending text bytes and the results they are due to give
    t_text_item text_bytes_q[$];
    t_result    due_glyphs[$];

    // decoder state and register copies
    logic [7:0]  dec_lead, dec_second;
    logic [1:0]  dec_pending;
    logic        text_halted;
    logic [15:0] run_width;
    logic        run_clipped;
    logic [7:0]  cur_size, cur_style;

    bit          text_busy, cfg_done, steady;
    int unsigned send_gap, stall_left, cycles, mismatches;
    int unsigned n_texts, n_bytes, n_results, n_markers, n_clipped, n_double, n_cfg;
    logic [8:0]  directed_seq [24];

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [4:0] glyph_px(input logic [15:0] cp);
        logic [4:0] sz, base, extra;
        sz = (cur_size == 8'd0) ? 5'd1 : (cur_size > 8'd2) ? 5'd2 : cur_size[4:0];
        base = (cp == SHARP_S) ? 5'd12 : 5'd6;
        extra = 5'd0;
        if (cur_style == STYLE_BOLD || cur_style == STYLE_BLOCK) extra = 5'd1;
        else if (cur_style == STYLE_WIDE) extra = sz;
        return base * sz + extra;
    endfunction

    function automatic void push_glyph(input logic [15:0] cp, input logic last);
        t_result r;
        logic [4:0] adv;
        if (text_halted) return;
        r = '0;
        if (cp == 16'd0) begin
            // zero value: end marker, the rest of the text is dropped
            r.last_result = 1'b1;
            text_halted = 1'b1;
        end else begin
            adv = glyph_px(cp);
            run_width = run_width + adv;
            if (run_width > WIDTH_MAX) begin
                run_width = WIDTH_MAX;
                run_clipped = 1'b1;
            end
            r.codepoint = cp;
            r.glyph_present = 1'b1;
            r.advance = adv;
            r.last_result = last;
        end
        r.total_width = run_width[14:0];
        r.width_saturated = run_clipped;
        due_glyphs.push_back(r);
    endfunction

    function automatic void start_lead(input logic [7:0] b, input logic last);
        if (!b[7]) push_glyph({8'h00, b}, last);
        else if (b[7:5] == 3'b110 && !last) begin
            dec_lead = b;
            dec_pending = 2'd1;
        end else if (b[7:4] == 4'b1110 && !last) begin
            dec_lead = b;
            dec_pending = 2'd2;
        end else push_glyph(BAD_CODE, last);
    endfunction

    function automatic void clear_text();
        dec_lead = '0;
        dec_second = '0;
        dec_pending = '0;
        text_halted = 1'b0;
        run_width = '0;
        run_clipped = 1'b0;
    endfunction

    function automatic void measure_byte(input logic [7:0] b, input logic last);
        logic [15:0] cp;
        if (!text_halted) begin
            if (dec_pending == 2'd1) begin
                dec_pending = 2'd0;
                if (dec_lead[7:5] == 3'b110) cp = {5'd0, dec_lead[4:0], b[5:0]};
                else cp = {dec_lead[3:0], dec_second[5:0], b[5:0]};
                push_glyph(cp, last);
            end else if (dec_pending == 2'd2) begin
                if (last) begin
                    // three-byte sequence cut short: '?' then the byte as a new lead
                    dec_pending = 2'd0;
                    push_glyph(BAD_CODE, 1'b0);
                    start_lead(b, 1'b1);
                end else begin
                    dec_second = b;
                    dec_pending = 2'd1;
                end
            end else begin
                dec_pending = 2'd0;
                start_lead(b, last);
            end
        end
        if (last) clear_text();
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    function automatic void random_text();
        logic [7:0] bq[$];
        int unsigned units, r;
        units = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        repeat (units) begin
            r = $urandom_range(0, 99);
            if (r < 40) bq.push_back(8'($urandom_range(1, 127)));
            else if (r < 55) begin
                bq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                bq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'h80 | 8'($urandom_range(0, 63)));
            end else if (r < 70) begin
                bq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                repeat (2)
                    bq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                              : 8'h80 | 8'($urandom_range(0, 63)));
            end else if (r < 75) begin
                bq.push_back(8'hC3);
                bq.push_back(8'h9F);
            end else if (r < 80) bq.push_back(8'hC0 | 8'($urandom_range(0, 47)));
            else if (r < 97) bq.push_back(8'($urandom_range(0, 255)));
            else begin
                // zero value in one of its encodings
                case ($urandom_range(0, 2))
                    0: bq.push_back(8'h00);
                    1: begin bq.push_back(8'hC0); bq.push_back(8'h80); end
                    default: begin bq.push_back(8'hE0); bq.push_back(8'h80); bq.push_back(8'h80); end
                endcase
            end
        end
        // sometimes the text ends inside a sequence
        case ($urandom_range(0, 9))
            0: bq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            1: bq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            2: begin
                bq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                bq.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        foreach (bq[i]) text_bytes_q.push_back({bq[i], 1'(i == bq.size() - 1)});
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_done = 1'b0;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        wait (cfg_done);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (text_bytes_q.size() != 0 || text_busy || due_glyphs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // byte driver
    always @(negedge i_clk) begin
        t_text_item nx;
        if (!i_rst_n) text_if.valid <= 1'b0;
        else if (!text_busy) begin
            if (send_gap > 0) begin
                send_gap--;
                text_if.valid <= 1'b0;
            end else if (text_bytes_q.size() > 0) begin
                nx = text_bytes_q.pop_front();
                text_if.text_byte   <= nx.text_byte;
                text_if.end_of_text <= nx.end_of_text;
                text_if.valid       <= 1'b1;
                text_busy = 1'b1;
                send_gap = pick_gap();
            end else text_if.valid <= 1'b0;
        end
    end

    // result sink stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // monitor: check results first, then predict from the byte taken at this edge
    always @(posedge i_clk) begin
        t_result want, got;
        int unsigned depth;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.codepoint       = res_if.codepoint;
            got.glyph_present   = res_if.glyph_present;
            got.advance         = res_if.advance;
            got.total_width     = res_if.total_width;
            got.width_saturated = res_if.width_saturated;
            got.last_result     = res_if.last_result;
            n_results++;
            if (!got.glyph_present) n_markers++;
            if (got.width_saturated) n_clipped++;
            if (due_glyphs.size() == 0) begin
                $display("%0t: result with none expected, actual codepoint %0d width %0d",
                         $time, got.codepoint, got.total_width);
                mismatches++;
            end else begin
                want = due_glyphs.pop_front();
                check_field("codepoint", want.codepoint, got.codepoint);
                check_field("glyph_present", 16'(want.glyph_present), 16'(got.glyph_present));
                check_field("advance", 16'(want.advance), 16'(got.advance));
                check_field("total_width", 16'(want.total_width), 16'(got.total_width));
                check_field("width_saturated", 16'(want.width_saturated),
                            16'(got.width_saturated));
                check_field("last_result", 16'(want.last_result), 16'(got.last_result));
            end
        end
        if (i_rst_n && text_if.valid && text_if.ready) begin
            depth = due_glyphs.size();
            measure_byte(text_if.text_byte, text_if.end_of_text);
            if (due_glyphs.size() == depth + 2) n_double++;
            n_bytes++;
            if (text_if.end_of_text) n_texts++;
            text_busy = 1'b0;
        end
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            case (cfg_if.index)
                CFG_FONT_SIZE:  cur_size  = cfg_if.data;
                CFG_FONT_STYLE: cur_style = cfg_if.data;
                default: ;
            endcase
            n_cfg++;
            cfg_done = 1'b1;
        end
    end

    // watchdog, plus random stretches with no idling on either side
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 256 == 0) steady = ($urandom_range(0, 3) == 0);
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, due_glyphs.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [7:0] phase_size [10], phase_style [10];
        int unsigned start_bytes;
        i_rst_n = 1'b0;
        text_if.valid = 1'b0;
        text_if.text_byte = '0;
        text_if.end_of_text = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        cur_size = FONT_SIZE_RESET;
        cur_style = FONT_STYLE_RESET;
        clear_text();

        // bit 8 flags the last byte of a text
        directed_seq = '{
            9'h07F, 9'h001, 9'h0C3, 9'h09F, 9'h0E2, 9'h082, 9'h1AC, // ascii ends, sharp s, euro
            9'h0F8, 9'h080, 9'h1FF,                                 // bad leads
            9'h0E0, 9'h080, 9'h080, 9'h041, 9'h142,                 // zero value, rest dropped
            9'h0E4, 9'h141,                                         // three-byte cut at second
            9'h1C3,                                                 // two-byte cut at lead
            9'h100,                                                 // lone nul
            9'h0C0, 9'h080, 9'h1FF,                                 // overlong zero
            9'h0E0, 9'h180                                          // cut, new lead also bad
        };
        phase_size  = '{8'd0, 8'd2, 8'd255, 8'd3, 8'd1, 8'd2, 8'd0, 8'd1, 8'd128, 8'd2};
        phase_style = '{STYLE_BOLD, STYLE_WIDE, STYLE_BLOCK, 8'd255, 8'd4, FONT_STYLE_RESET,
                        STYLE_WIDE, STYLE_BOLD, STYLE_BLOCK, 8'd0};
        phase_size[9] = 8'($urandom_range(0, 255));
        phase_style[9] = 8'($urandom_range(0, 255));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_seq[i])
            text_bytes_q.push_back({directed_seq[i][7:0], directed_seq[i][8]});

        // each setting change waits for the block to drain completely
        for (int p = 0; p < 10; p++) begin
            wait_drained();
            write_reg(CFG_FONT_SIZE, phase_size[p]);
            write_reg(CFG_FONT_STYLE, phase_style[p]);
            start_bytes = text_bytes_q.size();
            while (text_bytes_q.size() - start_bytes < 40) random_text();
        end

        // one long text at the widest setting to drive the running width into saturation
        wait_drained();
        write_reg(CFG_FONT_SIZE, 8'd2);
        write_reg(CFG_FONT_STYLE, STYLE_WIDE);
        for (int i = 0; i < 2350; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                text_bytes_q.push_back({8'hC3, 1'b0});
                text_bytes_q.push_back({8'h9F, 1'b0});
            end
            text_bytes_q.push_back({8'($urandom_range(33, 126)), 1'(i == 2349)});
        end
        repeat (5) random_text();

        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("tb: %0d texts, %0d bytes, %0d results (%0d end markers, %0d two-result bytes)",
                 n_texts, n_bytes, n_results, n_markers, n_double);
        $display("tb: %0d register writes, %0d results with the width saturated",
                 n_cfg, n_clipped);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/u8tw_pkg.sv
rtl/u8tw_ifs.sv
rtl/u8tw_cfg_regs.sv
rtl/u8tw_decode.sv
rtl/u8tw_result_queue.sv
rtl/utf8_text_width_measure_core.sv
tb/tb_utf8_text_width_measure_core.sv
